[rtl/core/ahoc_pkg.sv]
// Shared types, codes and default sizes of the Aho-Corasick matcher.
`default_nettype none

package ahoc_pkg;

    localparam int MAX_NODES_DEF       = 1024;
    localparam int ALPHABET_DEF        = 26;
    localparam int MAX_PATTERN_LEN_DEF = 32;
    localparam int MAX_HITS            = 32;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_FIND   = 3'd1;
    localparam logic [2:0] OP_BUILD  = 3'd2;
    localparam logic [2:0] OP_MATCH  = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [2:0] KIND_HIT    = 3'd0;
    localparam logic [2:0] KIND_INSERT = 3'd1;
    localparam logic [2:0] KIND_FIND   = 3'd2;
    localparam logic [2:0] KIND_BUILD  = 3'd3;
    localparam logic [2:0] KIND_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_LONG = 2'd2;

    typedef struct packed {
        logic [2:0] op;
        logic [4:0] symbol;
        logic       first;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] position;
        logic [5:0]  length;
        logic        found;
        logic [1:0]  insert_status;
        logic        final_res;
    } out_item_t;

    typedef enum logic [2:0] {
        CMD_INSERT,
        CMD_FIND,
        CMD_BUILD,
        CMD_MATCH,
        CMD_CLEAR
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [4:0] symbol;
        logic       sym_ok;
        logic       first;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_head_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_START,
        S_CLR,
        S_INS_RD,
        S_INS_CHK,
        S_INS_FIN,
        S_FND_RD,
        S_FND_CHK,
        S_FND_ERD,
        S_FND_OUT,
        S_M_RD,
        S_M_CHK,
        S_C_RD,
        S_C_CHK,
        S_C_END,
        S_B_INIT,
        S_B_POP,
        S_B_PW,
        S_B_PF,
        S_B_CRD,
        S_B_CCHK,
        S_B_QRD,
        S_B_QCHK,
        S_B_DONE
    } state_t;

endpackage

`default_nettype wire

[rtl/core/aho_corasick_matcher.sv]
// Top level of the Aho-Corasick dictionary matcher.
`default_nettype none

// Aho-Corasick dictionary matcher over letters a-z. A beat is taken at a
// rising edge where start is high and busy is low; results come out on
// result, one beat per cycle, each marked by result_valid for exactly one
// cycle, and the receiver must take them as they come. A two-entry command
// queue sits between the front end and the table engine, so up to two
// beats can be taken while the engine is still working. A match follows
// failure links until the letter has a child or the walk is back at the
// root, and when the letter lands off the root it then walks the output
// chain through the pattern-end table. A build walks the trie breadth
// first, reading every letter slot of each node and following failure
// links. The child, link, pattern-end and queue memories are single-port,
// each with a registered read. After reset and on every clear the engine
// sweeps the child table one entry a cycle while busy stays high; a clear
// reports only when that sweep ends.
module aho_corasick_matcher
    import ahoc_pkg::*;
#(
    parameter int MAX_NODES       = MAX_NODES_DEF,
    parameter int ALPHABET        = ALPHABET_DEF,
    parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  item,
    output out_item_t result,
    output logic      result_valid
);

    cmd_head_t head;
    logic      pop;
    logic      clearing;

    // The front end decodes the op and drops unused codes.
    ahoc_front #(
        .ALPHABET(ALPHABET)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .clearing (clearing),
        .pop      (pop),
        .head     (head)
    );

    // The engine owns all tables and the result register.
    ahoc_back #(
        .MAX_NODES       (MAX_NODES),
        .ALPHABET        (ALPHABET),
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .clearing     (clearing),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

`default_nettype wire

[rtl/core/ahoc_ram.sv]
// Generic single-port RAM with registered read data.
`default_nettype none

module ahoc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/core/ahoc_front.sv]
// Front end: accepts beats, classifies the op and queues commands for the engine.
`default_nettype none

module ahoc_front
    import ahoc_pkg::*;
#(
    parameter int ALPHABET = ALPHABET_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  item,
    input  logic      clearing,
    input  logic      pop,
    output cmd_head_t head
);

    cmd_t       entries_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       cls_valid;
    cmd_t       cls_cmd;
    logic       push;
    logic       do_pop;

    always_comb
    begin
        cls_valid      = 1'b1;
        cls_cmd.symbol = item.symbol;
        cls_cmd.sym_ok = (32'(item.symbol) < ALPHABET);
        cls_cmd.first  = item.first;
        cls_cmd.last   = item.last;
        case (item.op)
            OP_INSERT: cls_cmd.op = CMD_INSERT;
            OP_FIND:   cls_cmd.op = CMD_FIND;
            OP_BUILD:  cls_cmd.op = CMD_BUILD;
            OP_MATCH:  cls_cmd.op = CMD_MATCH;
            OP_CLEAR:  cls_cmd.op = CMD_CLEAR;
            default:
            begin
                // Unused op codes are taken and dropped.
                cls_cmd.op = CMD_INSERT;
                cls_valid  = 1'b0;
            end
        endcase
    end

    assign busy       = (count_reg == 2'd2) || clearing;
    assign push       = start && !busy && cls_valid;
    assign do_pop     = pop && (count_reg != 2'd0);
    assign head.valid = (count_reg != 2'd0);
    assign head.cmd   = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= cls_cmd;
        end
    end

endmodule

`default_nettype wire

[rtl/core/ahoc_back.sv]
// Back end: the sequencer that runs insert, find, build, match and clear on the tables.
`default_nettype none

module ahoc_back
    import ahoc_pkg::*;
#(
    parameter int MAX_NODES       = MAX_NODES_DEF,
    parameter int ALPHABET        = ALPHABET_DEF,
    parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_head_t head,
    output logic      pop,
    output logic      clearing,
    output out_item_t result,
    output logic      result_valid
);

    localparam int NW     = $clog2(MAX_NODES);
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int CDEPTH = MAX_NODES * ALPHABET;
    localparam int CW     = $clog2(CDEPTH);
    localparam int SW     = $clog2(ALPHABET);
    localparam int LW     = $clog2(MAX_PATTERN_LEN + 1);
    localparam int HCW    = $clog2(MAX_HITS + 1);

    state_t          state_reg, state_next;
    cmd_t            item_reg, item_next;
    logic [NW-1:0]   cursor_reg, cursor_next;
    logic [NW-1:0]   walk_reg, walk_next;
    logic [CNT_W-1:0] nc_reg, nc_next;
    logic [LW-1:0]   depth_reg, depth_next;
    logic [1:0]      err_reg, err_next;
    logic            missed_reg, missed_next;
    logic [31:0]     pos_reg, pos_next;
    logic [31:0]     idx_reg, idx_next;
    logic [CNT_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] tail_reg, tail_next;
    logic [NW-1:0]   p_reg, p_next;
    logic [NW-1:0]   pf_reg, pf_next;
    logic [SW-1:0]   s_reg, s_next;
    logic [NW-1:0]   c_reg, c_next;
    logic [CW-1:0]   clr_reg, clr_next;
    logic            clr_emit_reg, clr_emit_next;
    logic [HCW-1:0]  hits_reg, hits_next;
    logic            pend_valid_reg, pend_valid_next;
    logic [31:0]     pend_pos_reg, pend_pos_next;
    logic [LW-1:0]   pend_len_reg, pend_len_next;
    out_item_t       res_reg, res_next;
    logic            res_valid_reg, res_valid_next;

    logic [NW-1:0]   child_node;
    logic [SW-1:0]   child_sym;
    logic [CW-1:0]   child_addr;
    logic            child_we;
    logic [NW-1:0]   child_wdata, child_rd;
    logic [NW-1:0]   fail_addr;
    logic            fail_we;
    logic [NW-1:0]   fail_wdata, fail_rd;
    logic [NW-1:0]   endl_addr;
    logic            endl_we;
    logic [LW:0]     endl_wdata, endl_rd;
    logic [NW-1:0]   queue_addr;
    logic            queue_we;
    logic [NW-1:0]   queue_wdata, queue_rd;

    logic [NW-1:0]   cur_e;
    logic [LW-1:0]   dep_e;
    logic [1:0]      err_e;
    logic            missed_e;
    logic [31:0]     pos_e;
    logic            ins_go;
    logic            ins_lookup;
    logic [NW-1:0]   m_c;
    logic            clr_last;
    logic            s_last;
    logic            b_link;
    logic            b_next_s;
    logic [NW-1:0]   b_link_val;
    logic [NW-1:0]   b_c;
    logic [32:0]     hit_sum;
    logic [31:0]     hit_pos;
    logic [LW-1:0]   hit_len;
    logic            hit_take;

    // Effective registers once a first flag has restarted at the root.
    assign cur_e      = item_reg.first ? '0 : cursor_reg;
    assign dep_e      = item_reg.first ? '0 : depth_reg;
    assign err_e      = item_reg.first ? ST_OK : err_reg;
    assign missed_e   = item_reg.first ? 1'b0 : missed_reg;
    assign pos_e      = item_reg.first ? 32'd0 : pos_reg;
    assign ins_go     = (err_e == ST_OK) && item_reg.sym_ok;
    assign ins_lookup = ins_go && (32'(dep_e) < MAX_PATTERN_LEN);
    assign m_c        = item_reg.sym_ok ? child_rd : '0;
    assign clr_last   = (clr_reg == CW'(CDEPTH - 1));
    assign s_last     = (s_reg == SW'(ALPHABET - 1));

    assign b_link = ((state_reg == S_B_CCHK) && (child_rd != '0) && (p_reg == '0)) ||
                    ((state_reg == S_B_QCHK) && ((child_rd != '0) || (walk_reg == '0)));
    assign b_next_s   = b_link || ((state_reg == S_B_CCHK) && (child_rd == '0));
    assign b_link_val = (state_reg == S_B_QCHK) ? child_rd : '0;
    assign b_c        = (state_reg == S_B_CCHK) ? child_rd : c_reg;

    assign hit_len  = endl_rd[LW-1:0];
    assign hit_sum  = {1'b0, idx_reg} + 33'd1;
    assign hit_take = endl_rd[LW] && (32'(hits_reg) < MAX_HITS);
    always_comb
    begin
        if (hit_len == '0)
        begin
            hit_pos = idx_reg;
        end
        else if (hit_sum >= 33'(hit_len))
        begin
            hit_pos = 32'(hit_sum - 33'(hit_len));
        end
        else
        begin
            hit_pos = 32'd0;
        end
    end

    assign child_addr = (state_reg == S_CLR) ? clr_reg
                      : CW'(CW'(child_node) * CW'(ALPHABET) + CW'(child_sym));

    ahoc_ram #(.WIDTH(NW), .DEPTH(CDEPTH)) u_child (
        .clk(clk), .we(child_we), .addr(child_addr), .wdata(child_wdata), .rdata(child_rd)
    );
    ahoc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_fail (
        .clk(clk), .we(fail_we), .addr(fail_addr), .wdata(fail_wdata), .rdata(fail_rd)
    );
    ahoc_ram #(.WIDTH(LW + 1), .DEPTH(MAX_NODES)) u_endl (
        .clk(clk), .we(endl_we), .addr(endl_addr), .wdata(endl_wdata), .rdata(endl_rd)
    );
    ahoc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (
        .clk(clk), .we(queue_we), .addr(queue_addr), .wdata(queue_wdata), .rdata(queue_rd)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                case (item_reg.op)
                    CMD_INSERT: state_next = ins_lookup ? S_INS_RD : S_INS_FIN;
                    CMD_FIND:
                    begin
                        if (!missed_e && item_reg.sym_ok)
                        begin
                            state_next = S_FND_RD;
                        end
                        else
                        begin
                            state_next = item_reg.last ? S_FND_ERD : S_IDLE;
                        end
                    end
                    CMD_BUILD:  state_next = S_B_INIT;
                    CMD_MATCH:  state_next = S_M_RD;
                    CMD_CLEAR:  state_next = S_CLR;
                    default:    state_next = S_IDLE;
                endcase
            end
            S_CLR:      state_next = clr_last ? S_IDLE : S_CLR;
            S_INS_RD:   state_next = S_INS_CHK;
            S_INS_CHK:  state_next = S_INS_FIN;
            S_INS_FIN:  state_next = S_IDLE;
            S_FND_RD:   state_next = S_FND_CHK;
            S_FND_CHK:  state_next = item_reg.last ? S_FND_ERD : S_IDLE;
            S_FND_ERD:  state_next = S_FND_OUT;
            S_FND_OUT:  state_next = S_IDLE;
            S_M_RD:     state_next = S_M_CHK;
            S_M_CHK:
            begin
                if ((m_c != '0) || (walk_reg == '0))
                begin
                    state_next = (m_c == '0) ? S_IDLE : S_C_RD;
                end
                else
                begin
                    state_next = S_M_RD;
                end
            end
            S_C_RD:     state_next = S_C_CHK;
            S_C_CHK:    state_next = (fail_rd == '0) ? S_C_END : S_C_RD;
            S_C_END:    state_next = S_IDLE;
            S_B_INIT:   state_next = S_B_POP;
            S_B_POP:    state_next = (head_reg == tail_reg) ? S_B_DONE : S_B_PW;
            S_B_PW:     state_next = S_B_PF;
            S_B_PF:     state_next = S_B_CRD;
            S_B_CRD:    state_next = S_B_CCHK;
            S_B_CCHK,
            S_B_QCHK:
            begin
                if (b_next_s)
                begin
                    state_next = s_last ? S_B_POP : S_B_CRD;
                end
                else
                begin
                    state_next = S_B_QRD;
                end
            end
            S_B_QRD:    state_next = S_B_QCHK;
            S_B_DONE:   state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath, memory controls and results.
    always_comb
    begin
        item_next       = item_reg;
        cursor_next     = cursor_reg;
        walk_next       = walk_reg;
        nc_next         = nc_reg;
        depth_next      = depth_reg;
        err_next        = err_reg;
        missed_next     = missed_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        p_next          = p_reg;
        pf_next         = pf_reg;
        s_next          = s_reg;
        c_next          = c_reg;
        clr_next        = clr_reg;
        clr_emit_next   = clr_emit_reg;
        hits_next       = hits_reg;
        pend_valid_next = pend_valid_reg;
        pend_pos_next   = pend_pos_reg;
        pend_len_next   = pend_len_reg;
        res_next        = '0;
        res_valid_next  = 1'b0;
        pop             = 1'b0;

        child_node  = cursor_reg;
        child_sym   = SW'(item_reg.symbol);
        child_we    = 1'b0;
        child_wdata = nc_reg[NW-1:0];
        fail_addr   = walk_reg;
        fail_we     = 1'b0;
        fail_wdata  = '0;
        endl_addr   = cursor_reg;
        endl_we     = 1'b0;
        endl_wdata  = {1'b1, depth_reg};
        queue_addr  = head_reg[NW-1:0];
        queue_we    = 1'b0;
        queue_wdata = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop       = 1'b1;
                    item_next = head.cmd;
                end
            end
            S_START:
            begin
                case (item_reg.op)
                    CMD_INSERT:
                    begin
                        cursor_next = cur_e;
                        depth_next  = dep_e;
                        err_next    = err_e;
                        if (ins_go && !ins_lookup)
                        begin
                            err_next = ST_LONG;
                        end
                    end
                    CMD_FIND:
                    begin
                        cursor_next = cur_e;
                        missed_next = missed_e || !item_reg.sym_ok;
                    end
                    CMD_MATCH:
                    begin
                        idx_next        = pos_e;
                        pos_next        = (&pos_e) ? pos_e : pos_e + 32'd1;
                        cursor_next     = cur_e;
                        walk_next       = cur_e;
                        hits_next       = '0;
                        pend_valid_next = 1'b0;
                    end
                    CMD_CLEAR:
                    begin
                        clr_next      = '0;
                        clr_emit_next = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_CLR:
            begin
                child_we    = 1'b1;
                child_wdata = '0;
                if (32'(clr_reg) < MAX_NODES)
                begin
                    fail_addr  = clr_reg[NW-1:0];
                    fail_we    = 1'b1;
                    endl_addr  = clr_reg[NW-1:0];
                    endl_we    = 1'b1;
                    endl_wdata = '0;
                end
                clr_next = clr_reg + CW'(1);
                if (clr_last)
                begin
                    nc_next     = CNT_W'(1);
                    cursor_next = '0;
                    pos_next    = 32'd0;
                    missed_next = 1'b0;
                    depth_next  = '0;
                    err_next    = ST_OK;
                    if (clr_emit_reg)
                    begin
                        res_next.kind      = KIND_CLEAR;
                        res_next.final_res = 1'b1;
                        res_valid_next     = 1'b1;
                    end
                end
            end
            S_INS_CHK:
            begin
                if (child_rd == '0)
                begin
                    if (32'(nc_reg) >= MAX_NODES)
                    begin
                        err_next = ST_FULL;
                    end
                    else
                    begin
                        child_we    = 1'b1;
                        cursor_next = nc_reg[NW-1:0];
                        nc_next     = nc_reg + CNT_W'(1);
                        depth_next  = depth_reg + LW'(1);
                    end
                end
                else
                begin
                    cursor_next = child_rd;
                    depth_next  = depth_reg + LW'(1);
                end
            end
            S_INS_FIN:
            begin
                if (item_reg.last)
                begin
                    endl_we = (err_reg == ST_OK) && (depth_reg != '0);
                    res_next.kind          = KIND_INSERT;
                    res_next.insert_status = err_reg;
                    res_next.final_res     = 1'b1;
                    res_valid_next         = 1'b1;
                end
            end
            S_FND_CHK:
            begin
                if (child_rd == '0)
                begin
                    missed_next = 1'b1;
                end
                else
                begin
                    cursor_next = child_rd;
                end
            end
            S_FND_OUT:
            begin
                res_next.kind      = KIND_FIND;
                res_next.found     = !missed_reg && endl_rd[LW];
                res_next.final_res = 1'b1;
                res_valid_next     = 1'b1;
            end
            S_M_RD:
            begin
                child_node = walk_reg;
            end
            S_M_CHK:
            begin
                if ((m_c != '0) || (walk_reg == '0))
                begin
                    cursor_next = m_c;
                    walk_next   = m_c;
                end
                else
                begin
                    walk_next = fail_rd;
                end
            end
            S_C_RD:
            begin
                endl_addr = walk_reg;
            end
            S_C_CHK:
            begin
                if (hit_take)
                begin
                    if (pend_valid_reg)
                    begin
                        res_next.kind     = KIND_HIT;
                        res_next.position = pend_pos_reg;
                        res_next.length   = 6'(pend_len_reg);
                        res_valid_next    = 1'b1;
                    end
                    pend_valid_next = 1'b1;
                    pend_pos_next   = hit_pos;
                    pend_len_next   = hit_len;
                    hits_next       = hits_reg + HCW'(1);
                end
                walk_next = fail_rd;
            end
            S_C_END:
            begin
                if (pend_valid_reg)
                begin
                    res_next.kind      = KIND_HIT;
                    res_next.position  = pend_pos_reg;
                    res_next.length    = 6'(pend_len_reg);
                    res_next.final_res = 1'b1;
                    res_valid_next     = 1'b1;
                end
                pend_valid_next = 1'b0;
            end
            S_B_INIT:
            begin
                fail_addr  = '0;
                fail_we    = 1'b1;
                queue_addr = '0;
                queue_we   = 1'b1;
                head_next  = '0;
                tail_next  = CNT_W'(1);
            end
            S_B_POP:
            begin
                if (head_reg != tail_reg)
                begin
                    head_next = head_reg + CNT_W'(1);
                end
            end
            S_B_PW:
            begin
                p_next    = queue_rd;
                fail_addr = queue_rd;
            end
            S_B_PF:
            begin
                pf_next = fail_rd;
                s_next  = '0;
            end
            S_B_CRD:
            begin
                child_node = p_reg;
                child_sym  = s_reg;
            end
            S_B_CCHK,
            S_B_QCHK:
            begin
                if (state_reg == S_B_CCHK)
                begin
                    c_next    = child_rd;
                    walk_next = pf_reg;
                end
                else if (!b_link)
                begin
                    walk_next = fail_rd;
                end
                if (b_link)
                begin
                    fail_addr  = b_c;
                    fail_we    = 1'b1;
                    fail_wdata = b_link_val;
                    if (32'(tail_reg) < MAX_NODES)
                    begin
                        queue_addr  = tail_reg[NW-1:0];
                        queue_we    = 1'b1;
                        queue_wdata = b_c;
                        tail_next   = tail_reg + CNT_W'(1);
                    end
                end
                if (b_next_s)
                begin
                    s_next = s_reg + SW'(1);
                end
            end
            S_B_QRD:
            begin
                child_node = walk_reg;
                child_sym  = s_reg;
            end
            S_B_DONE:
            begin
                res_next.kind      = KIND_BUILD;
                res_next.final_res = 1'b1;
                res_valid_next     = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            clr_reg        <= '0;
            clr_emit_reg   <= 1'b0;
            nc_reg         <= CNT_W'(1);
            cursor_reg     <= '0;
            pos_reg        <= 32'd0;
            missed_reg     <= 1'b0;
            depth_reg      <= '0;
            err_reg        <= ST_OK;
            hits_reg       <= '0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            clr_emit_reg   <= clr_emit_next;
            nc_reg         <= nc_next;
            cursor_reg     <= cursor_next;
            pos_reg        <= pos_next;
            missed_reg     <= missed_next;
            depth_reg      <= depth_next;
            err_reg        <= err_next;
            hits_reg       <= hits_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        walk_reg     <= walk_next;
        idx_reg      <= idx_next;
        head_reg     <= head_next;
        tail_reg     <= tail_next;
        p_reg        <= p_next;
        pf_reg       <= pf_next;
        s_reg        <= s_next;
        c_reg        <= c_next;
        pend_pos_reg <= pend_pos_next;
        pend_len_reg <= pend_len_next;
        res_reg      <= res_next;
    end

    assign clearing     = (state_reg == S_CLR);
    assign result       = res_reg;
    assign result_valid = res_valid_reg;

endmodule

`default_nettype wire

[tb/aho_corasick_matcher_test.sv]
// Self-checking testbench of the Aho-Corasick dictionary matcher.
`timescale 1ns / 1ps

module aho_corasick_matcher_test;
    import ahoc_pkg::*;

    localparam int NODES      = MAX_NODES_DEF;
    localparam int LETTERS    = ALPHABET_DEF;
    localparam int LONGEST    = MAX_PATTERN_LEN_DEF;
    // Quiet cycles allowed before the run is declared hung. A clear sweeps
    // the whole child table and a build on a full trie can take longer, so the
    // limit sits well above the sweep.
    localparam int QUIET_LIMIT = 16 * NODES * LETTERS;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_item_t  item;
    out_item_t result;
    logic      result_valid;

    aho_corasick_matcher u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result       (result),
        .result_valid (result_valid)
    );

    // Predictor state: a private copy of the trie and the cursor registers.
    logic [9:0]  trie_child [NODES*LETTERS];
    logic [9:0]  trie_fail [NODES];
    logic        trie_ends [NODES];
    logic [5:0]  trie_len [NODES];
    int unsigned trie_nodes;
    int unsigned walk_node;
    logic [31:0] text_index;
    logic        lookup_lost;
    int unsigned pattern_depth;
    logic [1:0]  pattern_status;

    out_item_t pending_results[$];
    int        error_count;
    int        quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned child_at(int unsigned node, int unsigned sym);
        if (node >= NODES || sym >= LETTERS)
            return 0;
        return trie_child[node*LETTERS + sym];
    endfunction

    function automatic out_item_t make_result(logic [2:0] kind, logic [31:0] pos,
                                              logic [5:0] len, logic fnd,
                                              logic [1:0] st, logic fin);
        out_item_t r;
        r.kind = kind;
        r.position = pos;
        r.length = len;
        r.found = fnd;
        r.insert_status = st;
        r.final_res = fin;
        return r;
    endfunction

    // Appends one expected result at the tail of the queue.
    task automatic expect_result(out_item_t r);
        pending_results.insert(pending_results.size(), r);
    endtask

    task automatic wipe_trie();
        for (int i = 0; i < NODES*LETTERS; i++)
            trie_child[i] = '0;
        for (int i = 0; i < NODES; i++)
        begin
            trie_fail[i] = '0;
            trie_ends[i] = 1'b0;
            trie_len[i] = '0;
        end
        trie_nodes = 1;
        walk_node = 0;
        text_index = '0;
        lookup_lost = 1'b0;
        pattern_depth = 0;
        pattern_status = ST_OK;
    endtask

    // Breadth-first walk that sets every failure link.
    task automatic link_failures();
        int unsigned order[$];
        int unsigned p, c, q, lnk, qc;
        trie_fail[0] = '0;
        order.insert(0, 0);
        while (order.size() > 0)
        begin
            p = order.pop_front();
            for (int unsigned s = 0; s < LETTERS; s++)
            begin
                c = child_at(p, s);
                if (c == 0)
                    continue;
                lnk = 0;
                if (p != 0)
                begin
                    q = trie_fail[p];
                    for (int g = 0; g < NODES; g++)
                    begin
                        qc = child_at(q, s);
                        if (qc != 0)
                        begin
                            lnk = qc;
                            break;
                        end
                        if (q == 0)
                            break;
                        q = trie_fail[q];
                    end
                end
                trie_fail[c] = 10'(lnk);
                order.insert(order.size(), c);
            end
        end
    endtask

    // Works out the results of one accepted beat and queues them.
    task automatic predict_beat(in_item_t it);
        int unsigned c, cur, t, hits;
        logic [31:0] idx, pos;
        logic [5:0]  len;
        hits = 0;
        case (it.op)
            OP_INSERT:
            begin
                if (it.first)
                begin
                    walk_node = 0;
                    pattern_depth = 0;
                    pattern_status = ST_OK;
                end
                if (pattern_status == ST_OK && it.symbol < LETTERS)
                begin
                    if (pattern_depth >= LONGEST)
                        pattern_status = ST_LONG;
                    else
                    begin
                        c = child_at(walk_node, it.symbol);
                        if (c == 0)
                        begin
                            if (trie_nodes >= NODES)
                                pattern_status = ST_FULL;
                            else
                            begin
                                c = trie_nodes++;
                                trie_child[walk_node*LETTERS + it.symbol] = 10'(c);
                            end
                        end
                        if (pattern_status == ST_OK)
                        begin
                            walk_node = c;
                            pattern_depth++;
                        end
                    end
                end
                if (it.last)
                begin
                    if (pattern_status == ST_OK && pattern_depth != 0)
                    begin
                        trie_ends[walk_node] = 1'b1;
                        trie_len[walk_node] = 6'(pattern_depth);
                    end
                    expect_result(make_result(KIND_INSERT, 0, 0, 0, pattern_status, 1));
                end
            end
            OP_FIND:
            begin
                if (it.first)
                begin
                    walk_node = 0;
                    lookup_lost = 1'b0;
                end
                if (!lookup_lost)
                begin
                    c = child_at(walk_node, it.symbol);
                    if (c == 0)
                        lookup_lost = 1'b1;
                    else
                        walk_node = c;
                end
                if (it.last)
                    expect_result(make_result(KIND_FIND, 0, 0,
                        !lookup_lost && trie_ends[walk_node], ST_OK, 1));
            end
            OP_BUILD:
            begin
                link_failures();
                expect_result(make_result(KIND_BUILD, 0, 0, 0, ST_OK, 1));
            end
            OP_MATCH:
            begin
                if (it.first)
                begin
                    walk_node = 0;
                    text_index = '0;
                end
                idx = text_index;
                if (text_index != 32'hFFFF_FFFF)
                    text_index++;
                cur = walk_node;
                for (int g = 0; g < NODES; g++)
                begin
                    if (child_at(cur, it.symbol) != 0 || cur == 0)
                        break;
                    cur = trie_fail[cur];
                end
                cur = child_at(cur, it.symbol);
                walk_node = cur;
                t = cur;
                // Walk the output chain; each pattern end on it is a hit, up to MAX_HITS.
                for (int g = 0; g < NODES && t != 0; g++)
                begin
                    if (trie_ends[t] && hits < MAX_HITS)
                    begin
                        len = trie_len[t];
                        if (idx + 33'd1 >= len && idx != 32'hFFFF_FFFF)
                            pos = idx + 1 - len;
                        else if (idx == 32'hFFFF_FFFF)
                            pos = 32'hFFFF_FFFF - len + 1;
                        else
                            pos = '0;
                        if (len == 0)
                            pos = idx;
                        expect_result(make_result(KIND_HIT, pos, len, 0, ST_OK, 0));
                        hits++;
                    end
                    t = trie_fail[t];
                end
                if (hits > 0)
                    pending_results[pending_results.size()-1].final_res = 1'b1;
            end
            OP_CLEAR:
            begin
                wipe_trie();
                expect_result(make_result(KIND_CLEAR, 0, 0, 0, ST_OK, 1));
            end
            default:
            begin
                // Unused op codes leave everything untouched.
            end
        endcase
    endtask

    // Sends one beat after a random gap and predicts it once it is taken.
    // Start stays high across back-to-back beats and drops during a gap.
    task automatic send_beat(logic [2:0] op, logic [4:0] sym, logic fst, logic lst);
        in_item_t it;
        int gap;
        it.op = op;
        it.symbol = sym;
        it.first = fst;
        it.last = lst;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_beat(it);
    endtask

    task automatic send_word(logic [2:0] op, string w);
        for (int i = 0; i < w.len(); i++)
            send_beat(op, 5'(w[i] - "a"), i == 0, i == w.len() - 1);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // Result checker: every strobe is compared with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result beat %p", result);
            end
            else
            begin
                out_item_t exp_r;
                exp_r = pending_results.pop_front();
                if (exp_r !== result)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("result mismatch: expected %p, got %p", exp_r, result);
                end
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("aho_corasick_matcher_test: done, errors");
            $finish;
        end
    end

    // Dictionary basics: insert, find hits and misses, overlapping matches.
    task automatic test_dictionary();
        send_word(OP_INSERT, "he");
        send_word(OP_INSERT, "she");
        send_word(OP_INSERT, "his");
        send_word(OP_INSERT, "hers");
        send_beat(OP_INSERT, 0, 1, 0);
        send_beat(OP_INSERT, 25, 0, 1);
        send_word(OP_FIND, "she");
        send_word(OP_FIND, "sh");
        send_word(OP_FIND, "hx");
        send_beat(OP_BUILD, 0, 0, 0);
        send_word(OP_MATCH, "ushers");
        drain();
    endtask

    // Odd letters, empty patterns, unused ops and a continued match.
    task automatic test_special_cases();
        send_beat(OP_INSERT, 31, 1, 1);
        send_beat(OP_INSERT, 26, 1, 0);
        send_beat(OP_INSERT, 1, 0, 1);
        send_beat(OP_FIND, 31, 1, 1);
        send_beat(3'd5, 3, 1, 1);
        send_beat(3'd6, 0, 0, 0);
        send_beat(3'd7, 31, 1, 0);
        send_word(OP_INSERT, "zz");
        send_beat(OP_MATCH, 27, 1, 0);
        send_beat(OP_MATCH, 25, 0, 0);
        send_word(OP_FIND, "zz");
        send_beat(OP_MATCH, 25, 0, 1);
        drain();
    endtask

    // Over-long pattern, then a clear of the whole table.
    task automatic test_limits();
        for (int i = 0; i < LONGEST + 3; i++)
            send_beat(OP_INSERT, 5'(i % LETTERS), i == 0, i == LONGEST + 2);
        send_beat(OP_CLEAR, 0, 0, 0);
        drain();
    endtask

    // A chain of nested patterns "a", "aa", ... gives many hits per letter.
    task automatic test_many_hits();
        for (int n = 1; n <= 8; n++)
            for (int i = 0; i < n; i++)
                send_beat(OP_INSERT, 0, i == 0, i == n - 1);
        send_beat(OP_INSERT, 0, 0, 1);
        send_beat(OP_BUILD, 0, 0, 0);
        for (int i = 0; i < 12; i++)
            send_beat(OP_MATCH, 0, i == 0, 0);
        drain();
        send_beat(OP_CLEAR, 0, 0, 0);
        drain();
    endtask

    // Random dictionary over a small alphabet so that text hits are common.
    task automatic test_random();
        int kind, n, beats;
        beats = 0;
        while (beats < 230)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 5)
            begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                    send_beat(OP_INSERT, 5'($urandom_range(0, 3)), i == 0, i == n - 1);
                beats += n;
            end
            else if (kind < 8)
            begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++)
                    send_beat(OP_FIND, 5'($urandom_range(0, 3)), i == 0, i == n - 1);
                beats += n;
            end
            else if (kind < 10)
            begin
                send_beat(OP_BUILD, 0, 0, 0);
                beats++;
            end
            else if (kind < 17)
            begin
                n = $urandom_range(3, 12);
                for (int i = 0; i < n; i++)
                    send_beat(OP_MATCH, 5'($urandom_range(0, 3)), i == 0,
                              1'($urandom_range(0, 1)));
                beats += n;
            end
            else
            begin
                // Noise: any field value at all.
                send_beat(($urandom_range(0, 7) == 4) ? OP_FIND : 3'($urandom_range(0, 7)),
                          5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
                beats++;
            end
        end
        drain();
    endtask

    initial
    begin
        error_count = 0;
        quiet_cycles = 0;
        start = 1'b0;
        item = '0;
        wipe_trie();
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_dictionary();
        test_special_cases();
        test_limits();
        test_many_hits();
        test_random();
        if (error_count == 0 && pending_results.size() == 0)
            $display("aho_corasick_matcher_test: done, clean");
        else
            $display("aho_corasick_matcher_test: done, errors");
        $finish;
    end

endmodule
